@@ rtl/core/hstd_pkg.sv @@
// Shared types and constants of the hall sensor threshold and debounce block.
// No dependencies; the interfaces and all modules use it by scoped names.
`default_nettype none

package hstd_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 6;
  localparam int RD_W     = 12;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ROW_W    = 2;
  localparam int COL_W    = 4;
  localparam int THR_W    = 13;
  localparam int FACTOR_W = 8;
  localparam int PROD_W   = RD_W + FACTOR_W;

  localparam int PCT_W    = 7;
  localparam int DEB_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam int PCT_SCALE = 100;
  localparam logic [THR_W-1:0] THR_MAX = 13'h1FFF;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FLOATING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERCENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RD   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   sensor_id;
    logic [RD_W-1:0]   reading;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pressed;
    logic                state_changed;
    logic [ROW_W-1:0]    key_row;
    logic [COL_W-1:0]    matrix_column;
    logic [THR_W-1:0]    threshold_value;
  } out_item_t;

  // one key entry: debounced state and time of its last change
  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] change_time;
  } key_entry_t;

endpackage

`default_nettype wire

@@ rtl/core/hstd_if.sv @@
// Valid/ready channel interfaces for sensor samples and detector results.
// Depends on hstd_pkg for the payload types.
`default_nettype none

interface hstd_in_if;
  logic               valid;
  logic               ready;
  hstd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hstd_out_if;
  logic                valid;
  logic                ready;
  hstd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hstd_pct_div.sv @@
// Threshold scaling: divides baseline*factor by 100 and saturates to 13 bits.
// Depends on hstd_pkg for widths and the scale constant.
`default_nettype none

module hstd_pct_div (
  input  wire logic [hstd_pkg::PROD_W-1:0] prod,
  output logic      [hstd_pkg::THR_W-1:0]  thr
);

  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_W     = hstd_pkg::PROD_W + 1;
  localparam int MUL_W       = hstd_pkg::PROD_W + RECIP_W;
  localparam int Q_W         = hstd_pkg::THR_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + hstd_pkg::PCT_SCALE - 1) / hstd_pkg::PCT_SCALE);

  logic [MUL_W-1:0] mul;
  logic [Q_W-1:0]   q;

  // reciprocal rounded up gives the exact quotient for every product below 2^20
  always_comb begin
    mul = MUL_W'(prod) * MUL_W'(RECIP);
    q   = mul[RECIP_SHIFT +: Q_W];
    thr = (q > Q_W'(hstd_pkg::THR_MAX)) ? hstd_pkg::THR_MAX : q[hstd_pkg::THR_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/hall_sensor_threshold_debounce.sv @@
// Hall sensor key detector: per-sensor calibrated threshold and lockout debounce.
// Pipeline: a sample is registered into stage 1 when it is accepted; its result is registered
// into the output register when stage 1 advances. Input stalls only while both stages are full.
// One sample per cycle while results are taken; thresholds and key states sit in two
// registered-read memories, with write-back forwarding for the same sensor on consecutive samples.
// Reset: config registers take their defaults; per-entry valid bits make every entry
// read as zero at once, so no clearing pass is needed. Uses hstd_pkg, hstd_if, hstd_pct_div.
`default_nettype none

module hall_sensor_threshold_debounce #(
  parameter int SENSORS          = 32,
  parameter int MATRIX_COLUMNS   = 12,
  parameter int MATRIX_ROWS_USED = 4,
  parameter int ADC_BITS         = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  hstd_in_if.sink                                 in_chan,
  hstd_out_if.source                              out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [hstd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hstd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ADDR_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int ID_W   = hstd_pkg::ID_W;
  localparam int RD_W   = hstd_pkg::RD_W;
  localparam int THR_W  = hstd_pkg::THR_W;
  localparam int TIME_W = hstd_pkg::TIME_W;
  localparam logic [RD_W-1:0] RD_MASK =
    (ADC_BITS >= RD_W) ? {RD_W{1'b1}} : RD_W'((1 << ADC_BITS) - 1);

  // configuration
  logic [hstd_pkg::PCT_W-1:0]  pct_r;
  logic                        pol_r;
  logic [hstd_pkg::DEB_W-1:0]  deb_r;
  logic [RD_W-1:0]             min_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r    <= hstd_pkg::PCT_W'(10);
      pol_r    <= 1'b0;
      deb_r    <= hstd_pkg::DEB_W'(5);
      min_rd_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hstd_pkg::CFG_PERCENT:  pct_r    <= cfg_wdata[hstd_pkg::PCT_W-1:0];
        hstd_pkg::CFG_POLARITY: pol_r    <= cfg_wdata[0];
        hstd_pkg::CFG_DEBOUNCE: deb_r    <= cfg_wdata[hstd_pkg::DEB_W-1:0];
        hstd_pkg::CFG_MIN_RD:   min_rd_r <= cfg_wdata[RD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [hstd_pkg::PCT_W-1:0]    pct_clamped;
  logic [hstd_pkg::FACTOR_W-1:0] factor;

  always_comb begin
    pct_clamped = (pct_r > hstd_pkg::PCT_W'(hstd_pkg::PCT_SCALE)) ?
                  hstd_pkg::PCT_W'(hstd_pkg::PCT_SCALE) : pct_r;
    factor = pol_r ?
             hstd_pkg::FACTOR_W'(hstd_pkg::PCT_SCALE) + hstd_pkg::FACTOR_W'(pct_clamped) :
             hstd_pkg::FACTOR_W'(hstd_pkg::PCT_SCALE) - hstd_pkg::FACTOR_W'(pct_clamped);
  end

  // sensor index to matrix position, constant per entry
  logic [ID_W-1:0] row_tab [SENSORS];
  logic [ID_W-1:0] col_tab [SENSORS];

  for (genvar g = 0; g < SENSORS; g++) begin : g_map
    assign row_tab[g] = ID_W'(g / MATRIX_COLUMNS);
    assign col_tab[g] = ID_W'(g % MATRIX_COLUMNS);
  end

  // handshake and input decode
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  logic [ID_W-1:0]   in_idx;
  logic [ADDR_W-1:0] in_addr;
  logic              in_id_ok;
  logic [RD_W-1:0]   in_rd;

  always_comb begin
    in_idx   = in_chan.data.sensor_id - ID_W'(1);
    in_addr  = in_idx[ADDR_W-1:0];
    in_id_ok = (in_chan.data.sensor_id != '0) &&
               ({1'b0, in_chan.data.sensor_id} <= (ID_W + 1)'(SENSORS));
    in_rd    = in_chan.data.reading & RD_MASK;
  end

  // stage 1 item
  logic [hstd_pkg::CMD_W-1:0]  s1_cmd_r;
  logic                        s1_id_ok_r;
  logic [ADDR_W-1:0]           s1_addr_r;
  logic [ID_W-1:0]             s1_row_r;
  logic [ID_W-1:0]             s1_col_r;
  logic [RD_W-1:0]             s1_rd_r;
  logic [TIME_W-1:0]           s1_now_r;
  logic [hstd_pkg::PROD_W-1:0] s1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (in_acc) s1_valid_r <= 1'b1;
    else if (s1_adv) s1_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= in_chan.data.command;
      s1_id_ok_r <= in_id_ok;
      s1_addr_r  <= in_addr;
      s1_row_r   <= in_id_ok ? row_tab[in_addr] : '0;
      s1_col_r   <= in_id_ok ? col_tab[in_addr] : '0;
      s1_rd_r    <= in_rd;
      s1_now_r   <= in_chan.data.now_ms;
      s1_prod_r  <= hstd_pkg::PROD_W'(in_rd) * hstd_pkg::PROD_W'(factor);
    end
  end

  // write-back controls from stage 1
  logic                  thr_we;
  logic                  thr_clr;
  logic [THR_W-1:0]      thr_new;
  logic                  key_we;
  hstd_pkg::key_entry_t  key_wdata;

  // threshold memory with per-entry valid bits
  logic [THR_W-1:0]   thr_mem [SENSORS];
  logic [SENSORS-1:0] thr_vld_r;
  logic [THR_W-1:0]   thr_q_r;
  logic               thr_vld_q_r;
  logic               thr_fwd_r;
  logic [THR_W-1:0]   thr_fwd_val_r;

  always_ff @(posedge clk) begin
    if (thr_we) thr_mem[s1_addr_r] <= thr_new;
    if (in_acc && in_id_ok) thr_q_r <= thr_mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) thr_vld_r <= '0;
    else if (thr_clr) thr_vld_r <= '0;
    else if (thr_we) thr_vld_r[s1_addr_r] <= 1'b1;
  end

  // key memory: pressed state and last change time
  hstd_pkg::key_entry_t key_mem [SENSORS];
  logic [SENSORS-1:0]   key_vld_r;
  hstd_pkg::key_entry_t key_q_r;
  logic                 key_vld_q_r;
  logic                 key_fwd_r;
  hstd_pkg::key_entry_t key_fwd_val_r;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[s1_addr_r] <= key_wdata;
    if (in_acc && in_id_ok) key_q_r <= key_mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) key_vld_r <= '0;
    else if (key_we) key_vld_r[s1_addr_r] <= 1'b1;
  end

  // forward a write landing on the same edge as the read of that entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      thr_vld_q_r   <= in_id_ok ? thr_vld_r[in_addr] : 1'b0;
      key_vld_q_r   <= in_id_ok ? key_vld_r[in_addr] : 1'b0;
      thr_fwd_r     <= thr_clr || (thr_we && (s1_addr_r == in_addr));
      thr_fwd_val_r <= thr_clr ? '0 : thr_new;
      key_fwd_r     <= key_we && (s1_addr_r == in_addr);
      key_fwd_val_r <= key_wdata;
    end
  end

  logic [THR_W-1:0]     thr_cur;
  hstd_pkg::key_entry_t key_cur;
  logic [THR_W-1:0]     thr_calc;

  always_comb begin
    thr_cur = thr_fwd_r ? thr_fwd_val_r : (thr_vld_q_r ? thr_q_r : '0);
    key_cur = key_fwd_r ? key_fwd_val_r : (key_vld_q_r ? key_q_r : '0);
  end

  hstd_pct_div u_pct_div (
    .prod (s1_prod_r),
    .thr  (thr_calc)
  );

  // result and state update of the stage 1 item
  hstd_pkg::out_item_t res;
  logic                want;
  logic                lockout_over;
  logic                change;
  logic [TIME_W-1:0]   elapsed;

  always_comb begin
    res          = '0;
    thr_we       = 1'b0;
    thr_clr      = 1'b0;
    thr_new      = thr_calc;
    key_we       = 1'b0;
    want         = pol_r ? ({1'b0, s1_rd_r} > thr_cur) : ({1'b0, s1_rd_r} < thr_cur);
    elapsed      = s1_now_r - key_cur.change_time;
    lockout_over = elapsed > TIME_W'(deb_r);
    change       = lockout_over && (want != key_cur.pressed);
    key_wdata.pressed     = want;
    key_wdata.change_time = s1_now_r;
    case (s1_cmd_r) inside
      hstd_pkg::CMD_CLEAR: begin
        thr_clr = s1_adv;
      end
      hstd_pkg::CMD_CAL, hstd_pkg::CMD_SCAN: begin
        if (!s1_id_ok_r) begin
          res.status = hstd_pkg::ST_UNMAPPED;
        end else if (s1_cmd_r == hstd_pkg::CMD_CAL) begin
          res.key_row       = s1_row_r[hstd_pkg::ROW_W-1:0];
          res.matrix_column = s1_col_r[hstd_pkg::COL_W-1:0];
          if (s1_rd_r < min_rd_r) begin
            res.status          = hstd_pkg::ST_FLOATING;
            res.threshold_value = thr_cur;
          end else begin
            res.status          = hstd_pkg::ST_DONE;
            res.threshold_value = thr_calc;
            thr_we              = s1_adv;
          end
        end else if (s1_row_r >= ID_W'(MATRIX_ROWS_USED)) begin
          res.status = hstd_pkg::ST_OUTSIDE;
        end else begin
          res.status          = hstd_pkg::ST_DONE;
          res.key_row         = s1_row_r[hstd_pkg::ROW_W-1:0];
          res.matrix_column   = s1_col_r[hstd_pkg::COL_W-1:0];
          res.threshold_value = thr_cur;
          res.pressed         = change ? want : key_cur.pressed;
          res.state_changed   = change;
          key_we              = s1_adv && change;
        end
      end
      default: ;
    endcase
  end

  // output register
  hstd_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (s1_adv) out_valid_r <= 1'b1;
    else if (out_chan.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_data_r <= res;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

`ifndef SYNTH
  a_clear_drops_all: assert property (@(posedge clk) disable iff (!rst_n)
    thr_clr |=> (thr_vld_r == '0))
    else $error("threshold valid bits survive a clear");

  a_key_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> (s1_cmd_r == hstd_pkg::CMD_SCAN) && s1_id_ok_r && res.state_changed)
    else $error("key entry written outside a changing scan");

  a_key_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |=> key_vld_r[$past(s1_addr_r)])
    else $error("key entry written but not marked valid");

  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(thr_we && (thr_clr || key_we)))
    else $error("two memory updates from one transaction");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced transaction missing from output register");
`endif

endmodule

`default_nettype wire

@@ verif/hall_sensor_threshold_debounce_test.sv @@
// Self-checking bench for hall_sensor_threshold_debounce: directed and random sensor
// samples under several register settings, each result checked against a local model.
// Depends on hstd_pkg, hstd_if and the block itself.
`default_nettype none

module hall_sensor_threshold_debounce_test;

  localparam int NUM_KEYS        = 32;
  localparam int COLUMNS         = 12;
  localparam int ROWS_USED       = 4;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 118;
  localparam int PHASES          = 8;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_CYCLES     = 400;

  // Key detector model plus the queue of reports it expects, oldest first.
  class key_scoreboard;
    logic [hstd_pkg::PCT_W-1:0]  pct;
    logic                        pol;
    logic [hstd_pkg::DEB_W-1:0]  deb;
    logic [hstd_pkg::RD_W-1:0]   min_rd;
    logic [hstd_pkg::RD_W-1:0]   baseline_mem[NUM_KEYS];
    logic [hstd_pkg::THR_W-1:0]  thr_mem[NUM_KEYS];
    logic                        key_down[NUM_KEYS];
    logic [hstd_pkg::TIME_W-1:0] changed_at[NUM_KEYS];
    hstd_pkg::out_item_t         key_reports[$];
    int                          failures;

    function new();
      pct      = 7'd10;
      pol      = 1'b0;
      deb      = 8'd5;
      min_rd   = '0;
      failures = 0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        baseline_mem[k] = '0;
        thr_mem[k]      = '0;
        key_down[k]     = 1'b0;
        changed_at[k]   = '0;
      end
    endfunction

    function void set_reg(logic [hstd_pkg::CFG_IDX_W-1:0] idx,
                          logic [hstd_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        hstd_pkg::CFG_PERCENT:  pct    = value[hstd_pkg::PCT_W-1:0];
        hstd_pkg::CFG_POLARITY: pol    = value[0];
        hstd_pkg::CFG_DEBOUNCE: deb    = value[hstd_pkg::DEB_W-1:0];
        hstd_pkg::CFG_MIN_RD:   min_rd = value[hstd_pkg::RD_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending_count();
      return key_reports.size();
    endfunction

    function void note_sample(hstd_pkg::in_item_t s);
      hstd_pkg::out_item_t         r;
      int unsigned                 slot, p, thr;
      logic                        want;
      logic [hstd_pkg::TIME_W-1:0] elapsed;
      r = '0;
      if (s.command == hstd_pkg::CMD_CLEAR) begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          baseline_mem[k] = '0;
          thr_mem[k]      = '0;
        end
      end else if (s.command == hstd_pkg::CMD_CAL || s.command == hstd_pkg::CMD_SCAN) begin
        if (s.sensor_id == 0 || s.sensor_id > NUM_KEYS) begin
          r.status = hstd_pkg::ST_UNMAPPED;
        end else begin
          slot = s.sensor_id - 1;
          if (s.command == hstd_pkg::CMD_CAL) begin
            r.key_row       = hstd_pkg::ROW_W'(slot / COLUMNS);
            r.matrix_column = hstd_pkg::COL_W'(slot % COLUMNS);
            if (s.reading < min_rd) begin
              r.status          = hstd_pkg::ST_FLOATING;
              r.threshold_value = thr_mem[slot];
            end else begin
              p   = (pct > hstd_pkg::PCT_SCALE) ? hstd_pkg::PCT_SCALE : pct;
              thr = pol ? s.reading * (hstd_pkg::PCT_SCALE + p) / hstd_pkg::PCT_SCALE
                        : s.reading * (hstd_pkg::PCT_SCALE - p) / hstd_pkg::PCT_SCALE;
              if (thr > 32'(hstd_pkg::THR_MAX)) thr = 32'(hstd_pkg::THR_MAX);
              baseline_mem[slot] = s.reading;
              thr_mem[slot]      = thr[hstd_pkg::THR_W-1:0];
              r.threshold_value  = thr[hstd_pkg::THR_W-1:0];
            end
          end else if (slot / COLUMNS >= ROWS_USED) begin
            r.status = hstd_pkg::ST_OUTSIDE;
          end else begin
            want    = pol ? (s.reading > thr_mem[slot]) : (s.reading < thr_mem[slot]);
            elapsed = s.now_ms - changed_at[slot];
            // lockout: flip only once strictly more than the debounce time has passed
            if (elapsed > deb && want != key_down[slot]) begin
              key_down[slot]   = want;
              changed_at[slot] = s.now_ms;
              r.state_changed  = 1'b1;
            end
            r.pressed         = key_down[slot];
            r.key_row         = hstd_pkg::ROW_W'(slot / COLUMNS);
            r.matrix_column   = hstd_pkg::COL_W'(slot % COLUMNS);
            r.threshold_value = thr_mem[slot];
          end
        end
      end
      key_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want_val, logic [31:0] got_val);
      if (got_val !== want_val) begin
        $error("%s: expected %0d, got %0d", name, want_val, got_val);
        failures++;
      end
    endfunction

    function void check_result(hstd_pkg::out_item_t got);
      hstd_pkg::out_item_t want_r;
      if (key_reports.size() == 0) begin
        $error("result with no sample pending: status %0d", got.status);
        failures++;
        return;
      end
      want_r = key_reports.pop_front();
      compare_field("status", want_r.status, got.status);
      compare_field("pressed", want_r.pressed, got.pressed);
      compare_field("state_changed", want_r.state_changed, got.state_changed);
      compare_field("key_row", want_r.key_row, got.key_row);
      compare_field("matrix_column", want_r.matrix_column, got.matrix_column);
      compare_field("threshold_value", want_r.threshold_value, got.threshold_value);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [hstd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hstd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  hstd_in_if  in_chan ();
  hstd_out_if out_chan ();

  key_scoreboard sb = new();
  bit            calm;
  logic [31:0]   clock_ms;
  int unsigned   cycle_count = 0;

  hall_sensor_threshold_debounce u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  function automatic hstd_pkg::in_item_t sample(logic [hstd_pkg::CMD_W-1:0] cmd,
                                                logic [hstd_pkg::ID_W-1:0] id,
                                                logic [hstd_pkg::RD_W-1:0] rd,
                                                logic [hstd_pkg::TIME_W-1:0] now);
    hstd_pkg::in_item_t s;
    s.command   = cmd;
    s.sensor_id = id;
    s.reading   = rd;
    s.now_ms    = now;
    return s;
  endfunction

  // Hot keys get most samples so the debounce lockout is hit often.
  function automatic hstd_pkg::in_item_t random_sample();
    hstd_pkg::in_item_t s;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 2)       s.command = hstd_pkg::CMD_CLEAR;
    else if (pick < 5)  s.command = hstd_pkg::CMD_NONE;
    else if (pick < 30) s.command = hstd_pkg::CMD_CAL;
    else                s.command = hstd_pkg::CMD_SCAN;
    pick = $urandom_range(0, 19);
    if (pick == 0)      s.sensor_id = hstd_pkg::ID_W'($urandom_range(0, 63));
    else if (pick < 12) s.sensor_id = hstd_pkg::ID_W'($urandom_range(1, 4));
    else                s.sensor_id = hstd_pkg::ID_W'($urandom_range(1, NUM_KEYS));
    pick = $urandom_range(0, 19);
    if (pick == 0)      s.reading = '0;
    else if (pick == 1) s.reading = '1;
    else if (s.command == hstd_pkg::CMD_CAL && pick > 3)
      s.reading = hstd_pkg::RD_W'($urandom_range(800, 3200));
    else
      s.reading = hstd_pkg::RD_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 32) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 2 * sb.deb + 3);
    s.now_ms = clock_ms;
    return s;
  endfunction

  // Offer one transaction after a random gap; hold valid until it is taken.
  task automatic send_sample(hstd_pkg::in_item_t s);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.data  <= s;
    in_chan.valid <= 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.note_sample(s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [hstd_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[hstd_pkg::CFG_DATA_W-1:0];
    sb.set_reg(idx, value[hstd_pkg::CFG_DATA_W-1:0]);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(int unsigned p, int unsigned pol, int unsigned d,
                                int unsigned m);
    drain();
    write_reg(hstd_pkg::CFG_PERCENT, p);
    write_reg(hstd_pkg::CFG_POLARITY, pol);
    write_reg(hstd_pkg::CFG_DEBOUNCE, d);
    write_reg(hstd_pkg::CFG_MIN_RD, m);
  endtask

  // Result side: random stalls, one long hold-off to back the block up.
  initial begin
    int stall;
    int seen;
    seen = 0;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = (seen == HOLD_AT) ? HOLD_CYCLES : draw_gap();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      sb.check_result(out_chan.data);
      seen++;
    end
  end

  initial begin
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    calm           = 1'b0;
    clock_ms       = '0;
    rst_n          = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset settings: 10 percent, negative polarity, 5 ms lockout
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'd2000, 32'd10));   // uncalibrated key
    send_sample(sample(hstd_pkg::CMD_NONE, 6'd5, 12'hFFF, 32'hFFFF_FFFF));
    send_sample(sample(hstd_pkg::CMD_CAL, 6'd0, 12'd100, 32'd0));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd33, 12'd100, 32'd0));
    send_sample(sample(hstd_pkg::CMD_CAL, 6'd63, 12'hFFF, 32'd0));
    send_sample(sample(hstd_pkg::CMD_CAL, 6'd1, 12'hFFF, 32'd0));
    send_sample(sample(hstd_pkg::CMD_CAL, 6'd32, 12'd0, 32'd0));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd32, 12'd0, 32'd50));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'd0, 32'd100));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'hFFF, 32'd103));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'hFFF, 32'd105));   // exactly at lockout
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'hFFF, 32'd106));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'd0, 32'hFFFF_FFFE));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'hFFF, 32'd3));     // across the wrap
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'hFFF, 32'd4));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'd0, 32'd20));
    send_sample(sample(hstd_pkg::CMD_CLEAR, 6'd12, 12'd77, 32'd21));   // pressed state survives
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'hFFF, 32'd22));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd1, 12'hFFF, 32'd40));

    // clamped percent, positive polarity, zero lockout time, floating floor at top
    apply_settings(127, 1, 0, 4095);
    send_sample(sample(hstd_pkg::CMD_CAL, 6'd12, 12'd4094, 32'd41));
    send_sample(sample(hstd_pkg::CMD_CAL, 6'd12, 12'hFFF, 32'd41));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd12, 12'hFFF, 32'd41));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd13, 12'd1, 32'd42));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd13, 12'd0, 32'd42));
    send_sample(sample(hstd_pkg::CMD_SCAN, 6'd13, 12'd0, 32'd43));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings(10, 0, 5, 0);
        1: apply_settings(0, 1, 0, 0);
        2: apply_settings(100, 0, 255, 0);
        3: apply_settings(127, 1, 3, 4095);
        4: apply_settings(101, 0, 1, 1200);
        5: apply_settings($urandom_range(0, 100), 1, $urandom_range(0, 255),
                          $urandom_range(0, 2000));
        6: apply_settings($urandom_range(0, 127), 0, $urandom_range(0, 20),
                          $urandom_range(0, 4095));
        default: apply_settings(50, 1, 8, 700);
      endcase
      calm = (ph == 2 || ph == 5);
      if (ph == 3) clock_ms = 32'hFFFF_FF00;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_sample(random_sample());
    end

    calm = 1'b0;
    drain();
    // catch any result the block emits beyond the expected ones
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
